/* sv/adaptive_batch_drop_throttle_top_defines.svh */
// Assertion macros shared by the throttle RTL.
`ifndef ADAPTIVE_BATCH_DROP_THROTTLE_TOP_DEFINES_SVH
`define ADAPTIVE_BATCH_DROP_THROTTLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define ABDT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("throttle same-cycle check failed");

// ante implies cons in the next cycle
`define ABDT_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("throttle next-cycle check failed");

`else

`define ABDT_ASSERT_IMP(name, ante, cons)
`define ABDT_ASSERT_NXT(name, ante, cons)

`endif

`endif

/* sv/abdt_pkg.sv */
// Types and constants of the adaptive batch drop throttle.
package abdt_pkg;

	localparam int SLOT_FW  = 4;
	localparam int CNT_W    = 7;
	localparam int CAP_W    = 16;
	localparam int Q_W      = 17;
	localparam int OUT_CW   = 32;
	localparam int CFG_IW   = 2;

	localparam logic [Q_W-1:0] Q_ONE  = 17'h10000;
	localparam logic [Q_W-1:0] Q_HALF = 17'h08000;

	// register indexes
	localparam logic [CFG_IW-1:0] CFG_ENABLE    = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_SMOOTHING = 2'd2;

	localparam logic [Q_W-1:0] THRESHOLD_RST = 17'd32768;
	localparam logic [Q_W-1:0] SMOOTHING_RST = 17'd6554;

	typedef struct packed {
		logic [SLOT_FW-1:0] slot_index;
		logic [CNT_W-1:0]   batch_count;
		logic [CAP_W-1:0]   upstream_capacity;
	} batch_t;

	typedef struct packed {
		logic [SLOT_FW-1:0] out_slot;
		logic [OUT_CW-1:0]  packet_number;
		logic               keep_packet;
		logic [OUT_CW-1:0]  drop_total;
		logic               batch_last;
	} result_t;

	// Q1.16 values above one are taken as one
	function automatic logic [Q_W-1:0] clamp_one(input logic [Q_W-1:0] v);
		return (v > Q_ONE) ? Q_ONE : v;
	endfunction

endpackage

/* sv/abdt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module abdt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/adaptive_batch_drop_throttle_top.sv */
// Top level of the adaptive batch drop throttle.
//
// Usage:
//  - batch channel (batch_valid/batch_ready/batch): one item announces a batch of
//    packets for a slot. batch_ready is high only while no batch is in work.
//  - result channel (result_valid/result_ready/result): one item per packet,
//    in packet order; batch_last marks the final one. An empty batch gives none.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//    only while the block is idle. Unknown indexes are ignored.
// Sequence:
//  - throttling off: the batch is loaded, then results follow one per cycle
//    while the result register is empty or the receiver takes it.
//  - throttling on: level update (two multiplies, one add) and a restoring
//    divider of 17 steps for the stride run between the load of the batch and
//    the first result; the divider is skipped when the level sits at zero or
//    one.
//  - per-slot packet and drop counters live in one RAM, read when the batch is
//    taken and written back with the last packet; valid bits stand in for zero.
// Reset clears the level, the valid bits (all counters read as zero) and the
// registers to their defaults. A stalled receiver holds the result register;
// the next batch may still be taken while the last result waits.
`include "adaptive_batch_drop_throttle_top_defines.svh"

module adaptive_batch_drop_throttle_top
	import abdt_pkg::*;
#(
	parameter int SLOTS      = 16,
	parameter int MAX_BATCH  = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              batch_valid,
	output logic              batch_ready,
	input  batch_t            batch,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [Q_W-1:0]    cfg_data
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BATCH);
	localparam int SLOT_CODES = 1 << SLOT_FW;
	localparam logic [4:0] DIV_LAST = 5'd16; // 17 quotient bits

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL_DECAY,
		ST_MUL_FILL,
		ST_UPDATE,
		ST_DIV_SETUP,
		ST_DIV,
		ST_MODE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MODE_KEEP_ALL,
		MODE_DROP_MULT,
		MODE_DROP_ALL,
		MODE_KEEP_MULT
	} mode_t;

	state_t state_q;

	// configuration
	logic           enable_q;
	logic [Q_W-1:0] thresh_q;
	logic [Q_W-1:0] smooth_q;

	// batch context
	logic [SLOT_FW-1:0]    slot_q;
	logic [CNT_W-1:0]      count_q;
	logic [CAP_W-1:0]      cap_q;
	logic                  hit_q;
	logic [COUNT_BITS-1:0] pkt_q;
	logic [COUNT_BITS-1:0] drop_q;
	logic [Q_W-1:0]        level_q;
	logic [Q_W-1:0]        decay_q;
	logic [32:0]           fill_q;
	logic [Q_W-1:0]        rem_q;
	logic [Q_W-1:0]        quo_q;
	logic [Q_W-1:0]        dvd_q;
	logic [15:0]           div_d_q;
	logic [4:0]            iter_q;
	mode_t                 mode_q;
	logic [CNT_W-1:0]      stride_q;
	logic [CNT_W-1:0]      phase_q;
	logic [CNT_W-1:0]      n_q;
	logic [SLOTS-1:0]      valid_q;

	logic    out_valid_q;
	result_t out_q;

	// slot reduction table: code mod SLOTS
	logic [SLOT_FW-1:0] slot_map [SLOT_CODES];
	for (genvar g = 0; g < SLOT_CODES; g++) begin : g_slot_map
		assign slot_map[g] = SLOT_FW'(g % SLOTS);
	end

	logic               accept;
	logic [SLOT_FW-1:0] in_slot;
	logic [CNT_W-1:0]   in_count;
	logic [SLOT_W-1:0]  rd_addr;

	assign batch_ready = (state_q == ST_IDLE);
	assign accept      = batch_valid && batch_ready;
	assign in_slot     = slot_map[batch.slot_index];
	assign in_count    = (batch.batch_count > MAX_CNT) ? MAX_CNT : batch.batch_count;
	assign rd_addr     = SLOT_W'(in_slot);
	assign cfg_ready   = 1'b1;

	// level arithmetic
	logic [Q_W-1:0] s_eff;
	logic [Q_W-1:0] t_eff;
	logic [33:0]    decay_prod;
	logic [32:0]    fill_prod;
	logic           over;
	logic [Q_W:0]   grown;
	logic [Q_W-1:0] lv_next;
	logic [Q_W-1:0] half_gap;

	assign s_eff      = clamp_one(smooth_q);
	assign t_eff      = clamp_one(thresh_q);
	assign decay_prod = {17'b0, level_q} * {17'b0, Q_ONE - s_eff};
	assign fill_prod  = {16'b0, t_eff} * {17'b0, cap_q};
	assign over       = {10'b0, count_q, 16'b0} > fill_q;
	assign grown      = {1'b0, decay_q} + (over ? {1'b0, s_eff} : '0);
	assign lv_next    = (grown > {1'b0, Q_ONE}) ? Q_ONE : grown[Q_W-1:0];
	assign half_gap   = (level_q >= Q_HALF) ? (Q_ONE - level_q) : level_q;

	// restoring divider step: 65536 / half_gap
	logic [Q_W-1:0] rem_sh;
	logic           div_ge;

	assign rem_sh = {rem_q[15:0], dvd_q[Q_W-1]};
	assign div_ge = rem_sh >= {1'b0, div_d_q};

	// packet decision
	logic                  adv;
	logic                  mult;
	logic                  keep;
	logic                  last;
	logic                  stride_emit;
	logic [COUNT_BITS-1:0] pkt_next;
	logic [COUNT_BITS-1:0] drop_next;
	logic [CNT_W-1:0]      n_inc;
	logic [CNT_W-1:0]      phase_inc;

	assign adv       = (state_q == ST_EMIT) && (!out_valid_q || result_ready);
	assign mult      = (phase_q == '0);
	assign n_inc     = n_q + CNT_W'(1);
	assign phase_inc = phase_q + CNT_W'(1);
	assign last      = (n_inc == count_q);
	assign pkt_next  = pkt_q + COUNT_BITS'(1);
	assign drop_next = drop_q + (keep ? '0 : COUNT_BITS'(1));
	assign stride_emit = (state_q == ST_EMIT)
		&& (mode_q == MODE_DROP_MULT || mode_q == MODE_KEEP_MULT);

	always_comb begin
		unique case (mode_q)
			MODE_KEEP_ALL:  keep = 1'b1;
			MODE_DROP_MULT: keep = !mult;
			MODE_DROP_ALL:  keep = 1'b0;
			MODE_KEEP_MULT: keep = mult;
			default:        keep = 1'b1;
		endcase
	end

	// per-slot counters: {drop, packet}
	logic                    ram_we;
	logic [2*COUNT_BITS-1:0] ram_rdata;

	assign ram_we = adv && last;

	abdt_ram #(
		.WIDTH (2 * COUNT_BITS),
		.DEPTH (SLOTS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (SLOT_W'(slot_q)),
		.wdata ({drop_next, pkt_next}),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			thresh_q <= THRESHOLD_RST;
			smooth_q <= SMOOTHING_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ENABLE:    enable_q <= cfg_data[0];
				CFG_THRESHOLD: thresh_q <= cfg_data;
				CFG_SMOOTHING: smooth_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// valid bits of the counter RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[SLOT_W'(slot_q)] <= 1'b1;
		end
	end

	// sequencer, level and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			mode_q      <= MODE_KEEP_ALL;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// a new result replaces the taken one; otherwise a take empties it
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_count != '0) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					mode_q  <= MODE_KEEP_ALL;
					state_q <= enable_q ? ST_MUL_DECAY : ST_EMIT;
				end
				ST_MUL_DECAY: state_q <= ST_MUL_FILL;
				ST_MUL_FILL:  state_q <= ST_UPDATE;
				ST_UPDATE: begin
					level_q <= lv_next;
					state_q <= ST_DIV_SETUP;
				end
				ST_DIV_SETUP: begin
					if (half_gap == '0) begin
						mode_q  <= (level_q == '0) ? MODE_KEEP_ALL : MODE_DROP_ALL;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (iter_q == '0) begin
						state_q <= ST_MODE;
					end
				end
				ST_MODE: begin
					if (level_q < Q_HALF) begin
						mode_q <= (quo_q > {10'b0, count_q}) ? MODE_KEEP_ALL
							: MODE_DROP_MULT;
					end else begin
						mode_q <= (quo_q > {10'b0, count_q}) ? MODE_DROP_ALL
							: MODE_KEEP_MULT;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (adv) begin
						out_q.out_slot      <= slot_q;
						out_q.packet_number <= OUT_CW'(pkt_q);
						out_q.keep_packet   <= keep;
						out_q.drop_total    <= OUT_CW'(drop_next);
						out_q.batch_last    <= last;
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q  <= in_slot;
			count_q <= in_count;
			cap_q   <= batch.upstream_capacity;
			hit_q   <= valid_q[rd_addr];
		end
		if (state_q == ST_LOAD) begin
			pkt_q    <= hit_q ? ram_rdata[COUNT_BITS-1:0] : '0;
			drop_q   <= hit_q ? ram_rdata[2*COUNT_BITS-1:COUNT_BITS] : '0;
			n_q      <= '0;
			phase_q  <= '0;
			stride_q <= '0;
		end
		if (state_q == ST_MUL_DECAY) begin
			decay_q <= decay_prod[32:16];
		end
		if (state_q == ST_MUL_FILL) begin
			fill_q <= fill_prod;
		end
		if (state_q == ST_DIV_SETUP) begin
			div_d_q <= half_gap[15:0];
			rem_q   <= '0;
			quo_q   <= '0;
			dvd_q   <= Q_ONE;
			iter_q  <= DIV_LAST;
		end
		if (state_q == ST_DIV) begin
			rem_q  <= div_ge ? (rem_sh - {1'b0, div_d_q}) : rem_sh;
			quo_q  <= {quo_q[Q_W-2:0], div_ge};
			dvd_q  <= {dvd_q[Q_W-2:0], 1'b0};
			iter_q <= iter_q - 5'd1;
		end
		if (state_q == ST_MODE) begin
			// only used when the stride is at most the count
			stride_q <= CNT_W'(quo_q);
		end
		if (adv) begin
			pkt_q   <= pkt_next;
			drop_q  <= drop_next;
			n_q     <= n_inc;
			phase_q <= (phase_inc == stride_q) ? '0 : phase_inc;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`ABDT_ASSERT_IMP(a_result_from_emit, $rose(result_valid), $past(state_q == ST_EMIT))
	`ABDT_ASSERT_IMP(a_level_in_range, 1'b1, level_q <= Q_ONE)
	`ABDT_ASSERT_IMP(a_index_below_count, state_q == ST_EMIT, n_q < count_q)
	`ABDT_ASSERT_IMP(a_stride_phase, stride_emit, (stride_q != '0) && (phase_q < stride_q))
	`ABDT_ASSERT_NXT(a_last_ends_batch, adv && last, state_q == ST_IDLE)

endmodule
